FILE: hw/rtl/refcounted_page_frame_allocator_macros.svh
// Assertion macros used by the checker
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define RPFA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPFA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpfa_pkg;

  localparam int WORD_W = 64;
  localparam int OFF_W  = 6;
  localparam int IDX_W  = 16;
  localparam int CNT_W  = 16;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC_ONE = 3'd0,
    REQ_ALLOC_TWO = 3'd1,
    REQ_FREE_ONE  = 3'd2,
    REQ_FREE_TWO  = 3'd3,
    REQ_ADD_REF   = 3'd4,
    REQ_READ      = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_NO_FREE      = 2'd1,
    STAT_ALREADY_FREE = 2'd2,
    STAT_RANGE        = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_LO,
    S_SCAN_HI,
    S_RD_A,
    S_EX_A,
    S_RD_B,
    S_EX_B,
    S_WR_B,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_INC_SAT,
    ALU_DEC,
    ALU_ONE,
    ALU_ZERO
  } alu_op_t;

  typedef struct packed {
    logic pair;
    logic carry;
  } scan_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] pos;
    logic             low_free;
  } scan_res_t;

  function automatic logic [WORD_W-1:0] bit_upd(input logic [WORD_W-1:0] w,
                                                input logic [OFF_W-1:0]  off,
                                                input logic              val);
    logic [WORD_W-1:0] r;
    r      = w;
    r[off] = val;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rpfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rpfa_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfa_scan
  import rpfa_pkg::*;
(
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [WORD_W-1:0] vmask,
  input  wire scan_ctl_t         ctl,
  output scan_res_t              res
);

  logic [WORD_W-1:0] free_w;
  logic [WORD_W-1:0] pair_w;
  logic [OFF_W-1:0]  lo_pos;
  logic [OFF_W-1:0]  hi_pos;

  assign free_w = ~word & vmask;
  assign pair_w = free_w & {ctl.carry, free_w[WORD_W-1:1]};

  always_comb begin
    lo_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_w[i]) begin
        lo_pos = OFF_W'(i);
      end
    end
  end

  always_comb begin
    hi_pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (pair_w[i]) begin
        hi_pos = OFF_W'(i);
      end
    end
  end

  always_comb begin
    res.low_free = free_w[0];
    if (ctl.pair) begin
      res.hit = |pair_w;
      res.pos = hi_pos;
    end else begin
      res.hit = |free_w;
      res.pos = lo_pos;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/refcounted_page_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                              tuser
// in_       in   [15:0] page_index                  [2:0] req_type
// out_      out  [15:0] result_page [31:16] count_now [1:0] status
//
// Allocations scan the free bitmap one 64-page word a cycle through the shared
// search unit. Free, add-reference and read access one count; a pair free does
// the count RAM read-modify-write one page at a time.
// After reset a clear pass zeroes every bitmap word.
// A request may be accepted while the previous result still waits on out_tready.

module refcounted_page_frame_allocator
  import rpfa_pkg::*;
#(
  parameter int NUM_PAGES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IDX_W-1:0]  in_tdata,   // [15:0] page_index
  input  wire logic [REQ_W-1:0]  in_tuser,   // [2:0] req_type
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [2*IDX_W-1:0]     out_tdata,  // [15:0] result_page, [31:16] count_now
  output logic [STAT_W-1:0]      out_tuser   // [1:0] status
);

  localparam int PW     = $clog2(NUM_PAGES);
  localparam int NWORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [WA-1:0] LAST_W = WA'(NWORDS - 1);
  localparam logic [WORD_W-1:0] LAST_MASK =
    {WORD_W{1'b1}} >> ((WORD_W - NUM_PAGES % WORD_W) % WORD_W);
  localparam logic [IDX_W:0] NP_EXT = (IDX_W + 1)'(NUM_PAGES);

  function automatic logic [WA-1:0] word_of(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] s;
    s = p >> OFF_W;
    return s[WA-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WA-1:0]     scan_w_r, scan_w_nxt;
  logic [WA-1:0]     chk_w_r, chk_w_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic              carry_r, carry_nxt;
  logic [WORD_W-1:0] prev_word_r, prev_word_nxt;
  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]  cnt_b_r, cnt_b_nxt;
  logic [WORD_W-1:0] word_a_r, word_a_nxt;
  logic [WORD_W-1:0] word_b_r, word_b_nxt;
  logic [IDX_W-1:0]  pg_b_r, pg_b_nxt;
  logic              cross_r, cross_nxt;
  logic              zero_r, zero_nxt;
  stat_t             stat_r, stat_nxt;
  logic [IDX_W-1:0]  rpage_r, rpage_nxt;
  logic [CNT_W-1:0]  rcount_r, rcount_nxt;
  logic [WA-1:0]     clr_r, clr_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [STAT_W-1:0] out_tuser_r, out_tuser_nxt;
  logic [2*IDX_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [PW-1:0]     c_raddr, c_waddr;
  logic [CNT_W-1:0]  c_rdata, c_wdata;
  logic              c_we;
  logic [WA-1:0]     b_raddr, b_waddr;
  logic [WORD_W-1:0] b_rdata, b_wdata;
  logic              b_we;

  alu_op_t           alu_op;
  logic [CNT_W-1:0]  alu_a, alu_y;

  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;
  logic [WORD_W-1:0] vmask;

  logic [OFF_W-1:0]  rd_off;
  logic [CNT_W-1:0]  cur;
  logic              pair_zero;
  logic              same_word;
  logic [IDX_W-1:0]  found_pg;
  logic              rng_one, rng_two;
  logic              in_acc;
  logic              out_load;

  rpfa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_PAGES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  rpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  rpfa_scan u_scan (
    .word  (b_rdata),
    .vmask (vmask),
    .ctl   (scan_ctl),
    .res   (scan_res)
  );

  assign vmask    = (chk_w_r == LAST_W) ? LAST_MASK : '1;
  assign scan_ctl = '{pair: (state_r == S_SCAN_HI), carry: carry_r};
  assign found_pg = IDX_W'({chk_w_r, scan_res.pos});

  assign rd_off    = (state_r == S_EX_B) ? pg_b_r[OFF_W-1:0] : idx_r[OFF_W-1:0];
  assign cur       = b_rdata[rd_off] ? c_rdata : '0;
  assign pair_zero = (cnt_a_r == '0) || (cur == '0);
  assign same_word = (word_of(idx_r) == word_of(pg_b_r));

  assign rng_one = ({1'b0, in_tdata} >= NP_EXT);
  assign rng_two = (({1'b0, in_tdata} + (IDX_W + 1)'(1)) >= NP_EXT);

  assign in_acc   = in_tvalid && in_tready;
  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // shared count unit operands
  always_comb begin
    alu_a  = cur;
    alu_op = ALU_PASS;
    case (state_r)
      S_EX_A: begin
        case (req_r)
          REQ_FREE_ONE: alu_op = (cur == '0) ? ALU_PASS : ALU_DEC;
          REQ_ADD_REF:  alu_op = ALU_INC_SAT;
          default:      alu_op = ALU_PASS;
        endcase
      end
      S_EX_B: begin
        alu_a  = cnt_a_r;
        alu_op = pair_zero ? ALU_ZERO : ALU_DEC;
      end
      S_WR_B: begin
        alu_a = cnt_b_r;
        if (req_r == REQ_ALLOC_TWO) begin
          alu_op = ALU_ONE;
        end else begin
          alu_op = zero_r ? ALU_ZERO : ALU_DEC;
        end
      end
      default: begin
        alu_op = ALU_PASS;
      end
    endcase
  end

  always_comb begin
    case (alu_op)
      ALU_INC_SAT: alu_y = (alu_a == CNT_MAX) ? alu_a : alu_a + CNT_W'(1);
      ALU_DEC:     alu_y = alu_a - CNT_W'(1);
      ALU_ONE:     alu_y = CNT_W'(1);
      ALU_ZERO:    alu_y = '0;
      default:     alu_y = alu_a;
    endcase
  end

  // memory ports and in_tready
  always_comb begin
    in_tready = 1'b0;
    c_raddr   = idx_r[PW-1:0];
    c_we      = 1'b0;
    c_waddr   = idx_r[PW-1:0];
    c_wdata   = alu_y;
    b_raddr   = word_of(idx_r);
    b_we      = 1'b0;
    b_waddr   = word_of(idx_r);
    b_wdata   = bit_upd(b_rdata, idx_r[OFF_W-1:0], alu_y != '0);
    case (state_r)
      S_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_r;
        b_wdata = '0;
      end
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_SCAN_LO, S_SCAN_HI: begin
        b_raddr = scan_w_r;
        c_waddr = found_pg[PW-1:0];
        c_wdata = CNT_W'(1);
        b_waddr = chk_w_r;
        if (state_r == S_SCAN_HI) begin
          b_wdata = b_rdata | (WORD_W'(2'b11) << scan_res.pos);
        end else begin
          b_wdata = b_rdata | (WORD_W'(1) << scan_res.pos);
        end
        if (chk_v_r && scan_res.hit) begin
          c_we = 1'b1;
          b_we = 1'b1;
        end
      end
      S_EX_A: begin
        if (req_r != REQ_FREE_TWO) begin
          c_we = 1'b1;
          b_we = 1'b1;
        end
      end
      S_RD_B: begin
        c_raddr = pg_b_r[PW-1:0];
        b_raddr = word_of(pg_b_r);
      end
      S_EX_B: begin
        c_we    = 1'b1;
        b_we    = 1'b1;
        b_wdata = bit_upd(word_a_r, idx_r[OFF_W-1:0], alu_y != '0);
      end
      S_WR_B: begin
        c_we    = 1'b1;
        c_waddr = pg_b_r[PW-1:0];
        b_we    = (req_r == REQ_FREE_TWO) || cross_r;
        b_waddr = word_of(pg_b_r);
        b_wdata = bit_upd(word_b_r, pg_b_r[OFF_W-1:0], alu_y != '0);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    scan_w_nxt     = scan_w_r;
    chk_w_nxt      = chk_w_r;
    chk_v_nxt      = chk_v_r;
    carry_nxt      = carry_r;
    prev_word_nxt  = prev_word_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    word_a_nxt     = word_a_r;
    word_b_nxt     = word_b_r;
    pg_b_nxt       = pg_b_r;
    cross_nxt      = cross_r;
    zero_nxt       = zero_r;
    stat_nxt       = stat_r;
    rpage_nxt      = rpage_r;
    rcount_nxt     = rcount_r;
    clr_nxt        = clr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tuser_nxt  = out_tuser_r;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + WA'(1);
        if (clr_r == LAST_W) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_tuser;
          idx_nxt    = in_tdata;
          pg_b_nxt   = in_tdata + IDX_W'(1);
          chk_v_nxt  = 1'b0;
          carry_nxt  = 1'b0;
          stat_nxt   = STAT_OK;
          rpage_nxt  = in_tdata;
          rcount_nxt = '0;
          case (in_tuser)
            REQ_ALLOC_ONE: begin
              scan_w_nxt = '0;
              state_nxt  = S_SCAN_LO;
            end
            REQ_ALLOC_TWO: begin
              scan_w_nxt = LAST_W;
              state_nxt  = S_SCAN_HI;
            end
            REQ_FREE_ONE, REQ_ADD_REF, REQ_READ: begin
              if (rng_one) begin
                stat_nxt  = STAT_RANGE;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD_A;
              end
            end
            REQ_FREE_TWO: begin
              if (rng_two) begin
                stat_nxt  = STAT_RANGE;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD_A;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_LO, S_SCAN_HI: begin
        if (chk_v_r && scan_res.hit) begin
          stat_nxt   = STAT_OK;
          rpage_nxt  = found_pg;
          rcount_nxt = CNT_W'(1);
          pg_b_nxt   = found_pg + IDX_W'(1);
          cross_nxt  = (scan_res.pos == '1);
          word_b_nxt = prev_word_r;
          state_nxt  = (state_r == S_SCAN_HI) ? S_WR_B : S_DONE;
        end else if (chk_v_r && (((state_r == S_SCAN_LO) && (chk_w_r == LAST_W)) ||
                                 ((state_r == S_SCAN_HI) && (chk_w_r == '0)))) begin
          stat_nxt   = STAT_NO_FREE;
          rpage_nxt  = '0;
          rcount_nxt = '0;
          state_nxt  = S_DONE;
        end else begin
          chk_w_nxt     = scan_w_r;
          chk_v_nxt     = 1'b1;
          prev_word_nxt = b_rdata;
          carry_nxt     = chk_v_r ? scan_res.low_free : 1'b0;
          if (state_r == S_SCAN_LO) begin
            if (scan_w_r != LAST_W) begin
              scan_w_nxt = scan_w_r + WA'(1);
            end
          end else begin
            if (scan_w_r != '0) begin
              scan_w_nxt = scan_w_r - WA'(1);
            end
          end
        end
      end
      S_RD_A: begin
        state_nxt = S_EX_A;
      end
      S_EX_A: begin
        if (req_r == REQ_FREE_TWO) begin
          cnt_a_nxt  = cur;
          word_a_nxt = b_rdata;
          state_nxt  = S_RD_B;
        end else begin
          stat_nxt   = ((req_r == REQ_FREE_ONE) && (cur == '0)) ? STAT_ALREADY_FREE : STAT_OK;
          rcount_nxt = alu_y;
          state_nxt  = S_DONE;
        end
      end
      S_RD_B: begin
        state_nxt = S_EX_B;
      end
      S_EX_B: begin
        zero_nxt   = pair_zero;
        cnt_b_nxt  = cur;
        word_b_nxt = same_word ? b_wdata : b_rdata;
        stat_nxt   = pair_zero ? STAT_ALREADY_FREE : STAT_OK;
        rcount_nxt = alu_y;
        state_nxt  = S_WR_B;
      end
      S_WR_B: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = stat_r;
          out_tdata_nxt  = {rcount_r, rpage_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      chk_v_r      <= 1'b0;
      carry_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      chk_v_r      <= chk_v_nxt;
      carry_r      <= carry_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    idx_r       <= idx_nxt;
    scan_w_r    <= scan_w_nxt;
    chk_w_r     <= chk_w_nxt;
    prev_word_r <= prev_word_nxt;
    cnt_a_r     <= cnt_a_nxt;
    cnt_b_r     <= cnt_b_nxt;
    word_a_r    <= word_a_nxt;
    word_b_r    <= word_b_nxt;
    pg_b_r      <= pg_b_nxt;
    cross_r     <= cross_nxt;
    zero_r      <= zero_nxt;
    stat_r      <= stat_nxt;
    rpage_r     <= rpage_nxt;
    rcount_r    <= rcount_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rpfa_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "refcounted_page_frame_allocator_macros.svh"

module rpfa_chk
  import rpfa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic [IDX_W-1:0]   in_tdata,
  input wire logic [REQ_W-1:0]   in_tuser,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [2*IDX_W-1:0] out_tdata,
  input wire logic [STAT_W-1:0]  out_tuser
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `RPFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `RPFA_ASSERT_NOW(a_no_phantom, clk, rst_n, out_tvalid, pend_r != 2'd0, "result with no request outstanding")
  `RPFA_ASSERT_NOW(a_one_inflight, clk, rst_n, in_tready, pend_r < 2'd2, "ready with two requests outstanding")
  `RPFA_ASSERT_NOW(a_err_count, clk, rst_n, out_tvalid && (out_tuser == STAT_NO_FREE || out_tuser == STAT_ALREADY_FREE || out_tuser == STAT_RANGE), out_tdata[31:16] == 16'd0, "error result with nonzero count")
  `RPFA_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready held after a request")

endmodule

bind refcounted_page_frame_allocator rpfa_chk u_rpfa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
